>>> hw/rtl/s2c_pkg.sv
// ----------------------------------------------------------------------------
// s2c_pkg
// shared constants and calendar helpers for the seconds to date/time converter
// ----------------------------------------------------------------------------
package s2c_pkg;

    localparam logic [7:0]  LimitYearsReset = 8'd135;
    localparam logic [16:0] SecsPerDay      = 17'd86400;
    localparam logic [11:0] SecsPerHour     = 12'd3600;
    localparam logic [16:0] DaysPerYear     = 17'd365;

    // reciprocal multipliers, exact over the operand ranges used
    localparam logic [25:0] DayRecip  = 26'd50903317;
    localparam logic [16:0] YearRecip = 17'd91930;
    localparam logic [13:0] HourRecip = 14'd9321;
    localparam logic [10:0] MinRecip  = 11'd1093;

    localparam logic [8:0] MonthStart [13] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };

    function automatic logic is_leap(input logic [7:0] y);
        return (y[1:0] == 2'b00) && (y != 8'd100) && (y != 8'd200);
    endfunction

    function automatic logic [16:0] days_before_year(input logic [7:0] n);
        logic [9:0]  by4;
        logic [1:0]  c100;
        logic        c400;
        logic [16:0] base;
        by4 = ({2'b00, n} + 10'd3) >> 2;
        if (n == 8'd0)
            c100 = 2'd0;
        else if (n <= 8'd100)
            c100 = 2'd1;
        else if (n <= 8'd200)
            c100 = 2'd2;
        else
            c100 = 2'd3;
        c400 = (n != 8'd0);
        base = {9'd0, n} * DaysPerYear;
        return base + 17'(by4) - 17'(c100) + 17'(c400);
    endfunction

endpackage

>>> hw/rtl/s2c_if.sv
// ----------------------------------------------------------------------------
// s2c interfaces
// request, response and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface s2c_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] seconds;

    modport source (output valid, output seconds, input ready);
    modport sink   (input valid, input seconds, output ready);
endinterface

interface s2c_rsp_if;
    logic       valid;
    logic       ready;
    logic       valid_res;
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;

    modport source (output valid, output valid_res, output year, output month, output day,
                    output hour, output minute, output second, input ready);
    modport sink   (input valid, input valid_res, input year, input month, input day,
                    input hour, input minute, input second, output ready);
endinterface

interface s2c_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] year_limit;

    modport source (output valid, output year_limit, input ready);
    modport sink   (input valid, input year_limit, output ready);
endinterface

>>> hw/rtl/s2c_month_day.sv
// ----------------------------------------------------------------------------
// s2c_month_day
// splits a day of the year into month and day of month
// ----------------------------------------------------------------------------
module s2c_month_day (
    input  logic [8:0] doy,
    input  logic       leap,
    output logic [3:0] month,
    output logic [4:0] day
);
    import s2c_pkg::*;

    logic [3:0] cnt;
    logic [8:0] start;

    always_comb
    begin
        cnt = 4'd1;
        for (int m = 1; m < 12; m++)
        begin
            if (doy >= MonthStart[m] + ((m >= 2) ? 9'(leap) : 9'd0))
                cnt = cnt + 4'd1;
        end
        start = MonthStart[cnt - 4'd1] + ((cnt >= 4'd3) ? 9'(leap) : 9'd0);
    end

    assign month = cnt;
    assign day   = 5'(doy - start + 9'd1);

endmodule

>>> hw/rtl/seconds_to_calendar_datetime_unit.sv
// ----------------------------------------------------------------------------
// seconds_to_calendar_datetime_unit
// seconds since 2000-01-01 00:00:00 to gregorian date and time of day
// ----------------------------------------------------------------------------
// One request is taken every clock cycle unless input is blocked by a stall;
// its result passes through five register stages in order, the first loaded
// at the edge that takes it (day split, year and time split, limit check and
// hour, year correction and minute, month/day). Each stage holds its item
// until the next stage is free, so a stalled response only blocks input once
// every stage is full. The year limit is written over the cfg channel; the
// user must write it only while the unit is idle, not enforced by the block.
// A count past the limit returns valid_res low with every other field zero.
// ----------------------------------------------------------------------------
module seconds_to_calendar_datetime_unit (
    input  logic     clk,
    input  logic     rst_n,
    s2c_req_if.sink  req,
    s2c_rsp_if.source rsp,
    s2c_cfg_if.sink  cfg
);
    import s2c_pkg::*;

    logic [16:0] limit_days_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    // stage 1
    logic [50:0] day_prod;
    logic [31:0] secs1_reg, secs1_next;
    logic [15:0] days1_reg, days1_next;

    // stage 2
    logic [32:0] year_prod;
    logic [31:0] tod_wide;
    logic [15:0] days2_reg;
    logic [16:0] tod2_reg, tod2_next;
    logic [7:0]  y02_reg, y02_next;

    // stage 3
    logic [26:0] hour_prod;
    logic [15:0] days3_reg;
    logic [7:0]  y03_reg;
    logic [16:0] dby3_reg, dby3_next;
    logic        ok3_reg, ok3_next;
    logic [4:0]  hour3_reg, hour3_next;
    logic [11:0] rem3_reg, rem3_next;

    // stage 4
    logic        back;
    logic [16:0] dby_y;
    logic [20:0] min_prod;
    logic [7:0]  y4_reg, y4_next;
    logic [8:0]  doy4_reg, doy4_next;
    logic        ok4_reg;
    logic [4:0]  hour4_reg;
    logic [5:0]  min4_reg, min4_next;
    logic [5:0]  sec4_reg, sec4_next;

    // stage 5
    logic [3:0]  month5;
    logic [4:0]  day5;
    logic        ok5_reg;
    logic [7:0]  year5_reg;
    logic [3:0]  month5_reg;
    logic [4:0]  day5_reg;
    logic [4:0]  hour5_reg;
    logic [5:0]  min5_reg;
    logic [5:0]  sec5_reg;

    assign cfg.ready = 1'b1;

    // handshake chain
    assign en5       = !v5_reg || rsp.ready;
    assign en4       = !v4_reg || en5;
    assign en3       = !v3_reg || en4;
    assign en2       = !v2_reg || en3;
    assign en1       = !v1_reg || en2;
    assign req.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_days_reg <= days_before_year(LimitYearsReset);
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            v5_reg         <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                limit_days_reg <= days_before_year(cfg.year_limit);
            if (en1)
                v1_reg <= req.valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
            if (en5)
                v5_reg <= v4_reg;
        end
    end

    // stage 1: whole days
    always_comb
    begin
        day_prod   = 51'(req.seconds[31:7]) * 51'(DayRecip);
        secs1_next = req.seconds;
        days1_next = day_prod[50:35];
    end

    // stage 2: time of day and year estimate
    always_comb
    begin
        tod_wide  = secs1_reg - 32'(days1_reg) * 32'(SecsPerDay);
        tod2_next = tod_wide[16:0];
        year_prod = 33'(days1_reg) * 33'(YearRecip);
        y02_next  = year_prod[32:25];
    end

    // stage 3: limit check, year start, hour
    always_comb
    begin
        dby3_next  = days_before_year(y02_reg);
        ok3_next   = !(({1'b0, days2_reg} > limit_days_reg) ||
                       (({1'b0, days2_reg} == limit_days_reg) && (tod2_reg != 17'd0)));
        hour_prod  = 27'(tod2_reg[16:4]) * 27'(HourRecip);
        hour3_next = hour_prod[25:21];
        rem3_next  = 12'(tod2_reg - 17'(hour3_next) * 17'(SecsPerHour));
    end

    // stage 4: year correction, minute and second
    always_comb
    begin
        back      = dby3_reg > {1'b0, days3_reg};
        y4_next   = back ? (y03_reg - 8'd1) : y03_reg;
        dby_y     = back ? (dby3_reg - DaysPerYear - 17'(is_leap(y03_reg - 8'd1))) : dby3_reg;
        doy4_next = 9'({1'b0, days3_reg} - dby_y);
        min_prod  = 21'(rem3_reg[11:2]) * 21'(MinRecip);
        min4_next = min_prod[19:14];
        sec4_next = 6'(rem3_reg - 12'(min4_next) * 12'd60);
    end

    // stage 5: month and day
    s2c_month_day u_month_day (
        .doy   (doy4_reg),
        .leap  (is_leap(y4_reg)),
        .month (month5),
        .day   (day5)
    );

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            secs1_reg <= secs1_next;
            days1_reg <= days1_next;
        end
        if (en2)
        begin
            days2_reg <= days1_reg;
            tod2_reg  <= tod2_next;
            y02_reg   <= y02_next;
        end
        if (en3)
        begin
            days3_reg <= days2_reg;
            y03_reg   <= y02_reg;
            dby3_reg  <= dby3_next;
            ok3_reg   <= ok3_next;
            hour3_reg <= hour3_next;
            rem3_reg  <= rem3_next;
        end
        if (en4)
        begin
            y4_reg    <= y4_next;
            doy4_reg  <= doy4_next;
            ok4_reg   <= ok3_reg;
            hour4_reg <= hour3_reg;
            min4_reg  <= min4_next;
            sec4_reg  <= sec4_next;
        end
        if (en5)
        begin
            ok5_reg    <= ok4_reg;
            year5_reg  <= ok4_reg ? y4_reg    : 8'd0;
            month5_reg <= ok4_reg ? month5    : 4'd0;
            day5_reg   <= ok4_reg ? day5      : 5'd0;
            hour5_reg  <= ok4_reg ? hour4_reg : 5'd0;
            min5_reg   <= ok4_reg ? min4_reg  : 6'd0;
            sec5_reg   <= ok4_reg ? sec4_reg  : 6'd0;
        end
    end

    assign rsp.valid     = v5_reg;
    assign rsp.valid_res = ok5_reg;
    assign rsp.year      = year5_reg;
    assign rsp.month     = month5_reg;
    assign rsp.day       = day5_reg;
    assign rsp.hour      = hour5_reg;
    assign rsp.minute    = min5_reg;
    assign rsp.second    = sec5_reg;

endmodule
